// ===== rtl/f2h_pkg.sv =====
package f2h_pkg;
  localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;
  localparam logic [4:0] EXP_MAX16 = 5'h1f;
  localparam logic [14:0] HALF_INF = 15'h7c00;

  typedef struct packed {
    logic sign;
    logic [14:0] mag;
  } half_t;
endpackage

// ===== rtl/f2h_core.sv =====
module f2h_core
  import f2h_pkg::*;
(
  input  logic [31:0] single_bits,
  output half_t       half_bits
);
  logic [7:0]  exp_in;
  logic [22:0] mant;
  logic [23:0] sig;
  logic [4:0]  sh;
  logic [23:0] shifted;
  logic [23:0] rnd_src;
  logic [10:0] sub_m;
  logic [10:0] nrm_m;
  logic [4:0]  nrm_e;

  always_comb begin
    exp_in = single_bits[30:23];
    mant = single_bits[22:0];
    sig = {1'b1, mant};
    sh = 5'd0;
    shifted = '0;
    rnd_src = '0;
    sub_m = '0;
    nrm_m = {1'b0, mant[22:13]} + {10'd0, mant[12]};
    nrm_e = exp_in[4:0] - 5'd16 + {4'd0, nrm_m[10]};
    half_bits.sign = single_bits[31];
    half_bits.mag = '0;
    if (exp_in == 8'd0) begin
      half_bits.mag = '0;
    end else if (exp_in < 8'd102) begin
      half_bits.mag = '0;
    end else if (exp_in <= EXP_BIAS_DIFF) begin
      // Rebiased exponent -10..0: shift the significand by 14 - e.
      sh = 5'(8'd126 - exp_in);
      shifted = sig >> sh;
      rnd_src = sig >> (sh - 5'd1);
      sub_m = shifted[10:0] + {10'd0, rnd_src[0]};
      half_bits.mag = {4'd0, sub_m};
    end else if (exp_in >= 8'd143) begin
      half_bits.mag = HALF_INF;
    end else begin
      if (nrm_e == EXP_MAX16) begin
        half_bits.mag = HALF_INF;
      end else begin
        half_bits.mag = {nrm_e, nrm_m[9:0]};
      end
    end
  end
endmodule

// ===== rtl/float32_to_half_converter.sv =====
// Converts IEEE binary32 bit patterns to binary16 bit patterns.
// The input channel (in_valid, in_stall, in_single_bits) accepts a transfer
// when in_valid is high and in_stall is low. The result channel (out_valid,
// out_stall, out_half_bits) delivers a transfer the same way.
// The conversion is purely combinational between the input and the result
// register: a result appears in the cycle after its input transfer, and one
// item can be taken every cycle while the result channel is not stalled.
// When the receiver stalls a held result, the result register holds its value
// and the input side stalls as well, so nothing is lost.
// Synchronous reset clears the result valid flag but not the result data.
// Rounding is round-half-away on the highest dropped bit; overflow,
// infinity and NaN all give a signed infinity; tiny values flush to zero.
module float32_to_half_converter
  import f2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_single_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_half_bits
);
  half_t conv;
  logic  valid_r;
  logic [15:0] half_r;

  f2h_core u_core (
    .single_bits(in_single_bits),
    .half_bits(conv)
  );

  // The result register can take a new item whenever it is empty or drains now.
  assign in_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      half_r <= conv;
    end
  end

  assign out_valid = valid_r;
  assign out_half_bits = half_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_half_bits))
    else $error("result changed under stall");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item not shown");
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_half_bits[15] == $past(in_single_bits[31]))
    else $error("sign lost");
endmodule
